/* hw/rtl/modexp_pkg.sv */
// Shared types and constants for the modular exponentiation engine.
// Holds request and result formats, controller states and the command and
// status bundles between controller and datapath. No dependencies.
package modexp_pkg;

  localparam int KEY_BITS_DEF  = 1024;
  localparam int WORD_BITS_DEF = 64;

  typedef enum logic [1:0] {
    CMD_LOAD_BASE = 2'd0,
    CMD_LOAD_EXP  = 2'd1,
    CMD_LOAD_MOD  = 2'd2,
    CMD_START     = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [3:0]  word_index;
    logic [63:0] word_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_word;
    logic [3:0]  result_index;
    logic        last;
    logic        error;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DBL,
    ST_ADD,
    ST_WB,
    ST_ETEST,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    JOB_RED,
    JOB_MUL,
    JOB_SQR
  } job_t;

  typedef struct packed {
    logic load_word;
    logic init;
    logic check;
    logic ld_red;
    logic ld_mul;
    logic ld_sqr;
    logic dbl;
    logic add;
    logic wb_acc;
    logic wb_sq;
    logic e_shift;
    logic out_next;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic bit_last;
    logic e_zero;
    logic e_lsb;
    logic out_last;
  } dp_stat_t;

endpackage

/* hw/rtl/modexp_dp.sv */
// Datapath of the modular exponentiation engine: operand stores, the
// bit-serial modular multiplier, accumulator, square and result word select.
// Depends on modexp_pkg.
module modexp_dp #(
  parameter int KEY_BITS  = modexp_pkg::KEY_BITS_DEF,
  parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  modexp_pkg::in_item_t  in_data,
  input  modexp_pkg::dp_cmd_t   cmd,
  output modexp_pkg::dp_stat_t  stat,
  output modexp_pkg::out_item_t out_data
);
  import modexp_pkg::*;

  localparam int NW = (KEY_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int SW = NW * WORD_BITS;
  localparam int CW = $clog2(KEY_BITS + 1);
  localparam int OW = (NW > 1) ? $clog2(NW) : 1;

  logic [SW-1:0]       base_st, exp_st, mod_st;
  logic [KEY_BITS-1:0] modulus, acc, sq, r, a_sh, b_op, e_sh;
  logic [CW-1:0]       cnt;
  logic [OW-1:0]       out_cnt;
  logic                err;
  logic [KEY_BITS:0]   dbl_t, add_t, dbl_r, add_r;
  logic [SW-1:0]       acc_ext;
  logic [WORD_BITS-1:0] word_sel;

  assign modulus = mod_st[KEY_BITS-1:0];

  // Each half step leaves the partial result below twice the modulus, so one
  // conditional subtraction brings it back into range.
  always_comb begin
    dbl_t = {r, 1'b0};
    dbl_r = (dbl_t >= {1'b0, modulus}) ? dbl_t - {1'b0, modulus} : dbl_t;
    add_t = {1'b0, r} + {1'b0, b_op};
    add_r = (add_t >= {1'b0, modulus}) ? add_t - {1'b0, modulus} : add_t;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      for (int w = 0; w < NW; w++) begin
        if (int'(in_data.word_index) == w) begin
          unique case (in_data.command)
            CMD_LOAD_BASE: base_st[w*WORD_BITS +: WORD_BITS] <=
                             in_data.word_value[WORD_BITS-1:0];
            CMD_LOAD_EXP:  exp_st[w*WORD_BITS +: WORD_BITS] <=
                             in_data.word_value[WORD_BITS-1:0];
            CMD_LOAD_MOD:  mod_st[w*WORD_BITS +: WORD_BITS] <=
                             in_data.word_value[WORD_BITS-1:0];
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      sq      <= '0;
      err     <= 1'b0;
      cnt     <= '0;
      out_cnt <= '0;
    end else begin
      if (cmd.init) begin
        acc     <= KEY_BITS'(1);
        e_sh    <= exp_st[KEY_BITS-1:0];
        out_cnt <= '0;
      end
      if (cmd.check) begin
        err <= (modulus == '0);
        if (modulus == '0) begin
          acc <= '0;
          sq  <= '0;
        end
      end
      if (cmd.ld_red || cmd.ld_mul || cmd.ld_sqr) begin
        r   <= '0;
        cnt <= CW'(KEY_BITS);
      end
      if (cmd.ld_red) begin
        a_sh <= base_st[KEY_BITS-1:0];
        b_op <= KEY_BITS'(1);
      end
      if (cmd.ld_mul) begin
        a_sh <= acc;
        b_op <= sq;
      end
      if (cmd.ld_sqr) begin
        a_sh <= sq;
        b_op <= sq;
      end
      if (cmd.dbl) begin
        r <= dbl_r[KEY_BITS-1:0];
      end
      if (cmd.add) begin
        if (a_sh[KEY_BITS-1]) begin
          r <= add_r[KEY_BITS-1:0];
        end
        a_sh <= {a_sh[KEY_BITS-2:0], 1'b0};
        cnt  <= cnt - CW'(1);
      end
      if (cmd.wb_acc) begin
        acc <= r;
      end
      if (cmd.wb_sq) begin
        sq <= r;
      end
      if (cmd.e_shift) begin
        e_sh <= {1'b0, e_sh[KEY_BITS-1:1]};
      end
      if (cmd.out_next) begin
        out_cnt <= out_cnt + OW'(1);
      end
    end
  end

  assign acc_ext  = SW'(acc);
  assign word_sel = acc_ext[out_cnt*WORD_BITS +: WORD_BITS];

  always_comb begin
    stat.mod_zero = (modulus == '0);
    stat.bit_last = (cnt == CW'(1));
    stat.e_zero   = (e_sh == '0);
    stat.e_lsb    = e_sh[0];
    stat.out_last = (int'(out_cnt) == NW - 1);

    out_data.result_word  = 64'(word_sel);
    out_data.result_index = 4'(out_cnt);
    out_data.last         = stat.out_last;
    out_data.error        = err;
  end

endmodule

/* hw/rtl/modexp_ctrl.sv */
// Controller of the modular exponentiation engine: sequences the base
// reduction, the square-and-multiply scan and the result run.
// Depends on modexp_pkg.
module modexp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  modexp_pkg::cmd_t     in_command,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  modexp_pkg::dp_stat_t stat,
  output modexp_pkg::dp_cmd_t  cmd
);
  import modexp_pkg::*;

  state_t state, state_next;
  job_t   job, job_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      job   <= JOB_RED;
    end else begin
      state <= state_next;
      job   <= job_next;
    end
  end

  always_comb begin
    state_next = state;
    job_next   = job;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command == CMD_START) begin
            cmd.init   = 1'b1;
            state_next = ST_CHECK;
          end else begin
            cmd.load_word = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (stat.mod_zero) begin
          state_next = ST_OUT;
        end else begin
          cmd.ld_red = 1'b1;
          job_next   = JOB_RED;
          state_next = ST_DBL;
        end
      end
      ST_DBL: begin
        cmd.dbl    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = stat.bit_last ? ST_WB : ST_DBL;
      end
      ST_WB: begin
        unique case (job)
          JOB_MUL: begin
            // The square still holds its old value, so it can be reloaded now.
            cmd.wb_acc = 1'b1;
            cmd.ld_sqr = 1'b1;
            job_next   = JOB_SQR;
            state_next = ST_DBL;
          end
          JOB_SQR: begin
            cmd.wb_sq   = 1'b1;
            cmd.e_shift = 1'b1;
            state_next  = ST_ETEST;
          end
          default: begin
            cmd.wb_sq  = 1'b1;
            state_next = ST_ETEST;
          end
        endcase
      end
      ST_ETEST: begin
        if (stat.e_zero) begin
          state_next = ST_OUT;
        end else if (stat.e_lsb) begin
          cmd.ld_mul = 1'b1;
          job_next   = JOB_MUL;
          state_next = ST_DBL;
        end else begin
          cmd.ld_sqr = 1'b1;
          job_next   = JOB_SQR;
          state_next = ST_DBL;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.out_next = 1'b1;
          if (stat.out_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* hw/rtl/modular_exponentiation.sv */
// Modular exponentiation engine, base^exponent mod modulus.
// Load requests are accepted while idle. A start checks the modulus, then
// reduces the base and, for each exponent bit up to the highest set one,
// multiplies for a one bit and squares, using the bit-serial modular
// multiplier. The result words follow, flagged as an error for a zero modulus.
// Synchronous reset returns to idle with the accumulator cleared.
module modular_exponentiation #(
  parameter int KEY_BITS  = modexp_pkg::KEY_BITS_DEF,
  parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  modexp_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output modexp_pkg::out_item_t out_data
);
  import modexp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  modexp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_data.command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  modexp_dp #(
    .KEY_BITS  (KEY_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request taken during result run");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.error) |-> (out_data.result_word == 64'd0))
    else $error("error word not zero");
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_data.last) |=> out_valid)
    else $error("result run broken");
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last) |=> in_ready)
    else $error("not idle after last word");
`endif

endmodule

/* tb/sv/modular_exponentiation_test.sv */
// Self-checking testbench for the modular exponentiation engine.
// Drives load and start requests, predicts result words with wide integer
// arithmetic or takes them from the rows, checks them. Depends on modexp_pkg.
`timescale 1ns / 100ps

module modular_exponentiation_test;
  import modexp_pkg::*;

  localparam int NWORDS = 16;

  typedef struct {
    in_item_t    req;
    bit          known;
    logic [63:0] known_w0;
    bit          known_err;
  } step_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic [63:0] base_w [NWORDS];
  logic [63:0] exp_w [NWORDS];
  logic [63:0] mod_w [NWORDS];
  out_item_t   expected_words[$];
  int          mismatches = 0;
  bit          idling = 1'b1;
  int          stall_left = 0;
  step_row_t   rows[$];

  modular_exponentiation u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void push_run(logic [1023:0] value, bit err);
    out_item_t w;
    for (int k = 0; k < NWORDS; k++) begin
      w.result_word  = value[k*64 +: 64];
      w.result_index = k[3:0];
      w.last         = (k == NWORDS - 1);
      w.error        = err;
      expected_words.insert(expected_words.size(), w);
    end
  endfunction

  function automatic void add_row(step_row_t s);
    rows.insert(rows.size(), s);
  endfunction

  // Right-to-left square and multiply; the accumulator starts at one and is
  // never reduced when the exponent is zero.
  function automatic void predict_power();
    logic [2047:0] b, e, m, acc, sq;
    b = '0; e = '0; m = '0;
    for (int k = 0; k < NWORDS; k++) begin
      b[k*64 +: 64] = base_w[k];
      e[k*64 +: 64] = exp_w[k];
      m[k*64 +: 64] = mod_w[k];
    end
    if (m == 0) begin
      push_run('0, 1'b1);
    end else begin
      acc = 2048'(1);
      sq = b % m;
      for (int i = 0; i < 1024 && (e >> i) != 0; i++) begin
        if (e[i]) acc = (acc * sq) % m;
        sq = (sq * sq) % m;
      end
      push_run(acc[1023:0], 1'b0);
    end
  endfunction

  function automatic void note_request(in_item_t r);
    case (r.command)
      CMD_LOAD_BASE: base_w[r.word_index] = r.word_value;
      CMD_LOAD_EXP:  exp_w[r.word_index] = r.word_value;
      CMD_LOAD_MOD:  mod_w[r.word_index] = r.word_value;
      CMD_START:     predict_power();
    endcase
  endfunction

  task automatic send_request(in_item_t r, bit typed = 0, logic [63:0] w0 = '0,
                              bit err = 0);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed && r.command == CMD_START) push_run({960'b0, w0}, err);
    else note_request(r);
  endtask

  function automatic in_item_t make_req(cmd_t c, int idx, logic [63:0] v);
    in_item_t r;
    r.command = c; r.word_index = idx[3:0]; r.word_value = v;
    return r;
  endfunction

  function automatic logic [63:0] random_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic step_row_t row(cmd_t c, int idx, logic [63:0] v, bit typed = 0,
                                    logic [63:0] w0 = '0, bit err = 0);
    step_row_t s;
    s.req = make_req(c, idx, v); s.known = typed; s.known_w0 = w0; s.known_err = err;
    return s;
  endfunction

  // Receiver: random stalls while idling, checks against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          if (mismatches < 10) $display("Unexpected result word %h", out_data.result_word);
          mismatches++;
        end else begin
          out_item_t e;
          e = expected_words.pop_front();
          if (out_data.result_word !== e.result_word || out_data.result_index !== e.result_index
              || out_data.last !== e.last || out_data.error !== e.error) begin
            if (mismatches < 10)
              $display("Mismatch: expected word %h index %0d last %b error %b, got %h %0d %b %b",
                       e.result_word, e.result_index, e.last, e.error, out_data.result_word,
                       out_data.result_index, out_data.last, out_data.error);
            mismatches++;
          end
        end
      end
      if (idling && stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idling && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int sent;
    int rounds;
    logic [63:0] e0;
    for (int k = 0; k < NWORDS; k++) begin
      base_w[k] = '0; exp_w[k] = '0; mod_w[k] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Every operand word is written before the first start.
    for (int k = 0; k < NWORDS; k++) begin
      send_request(make_req(CMD_LOAD_BASE, k, '1));
      send_request(make_req(CMD_LOAD_EXP, k, '0));
      send_request(make_req(CMD_LOAD_MOD, k, '0));
    end

    // Zero modulus, then zero exponent with modulus one, then a base reduced to
    // nothing by modulus one, then a full-width modulus with exponents 2, 0, 5.
    add_row(row(CMD_START, 0, '1, 1, 64'd0, 1));
    add_row(row(CMD_LOAD_MOD, 0, 64'd1));
    add_row(row(CMD_START, 15, '0, 1, 64'd1, 0));
    add_row(row(CMD_LOAD_EXP, 0, 64'd1));
    add_row(row(CMD_START, 0, '0, 1, 64'd0, 0));
    add_row(row(CMD_LOAD_MOD, 15, '1));
    add_row(row(CMD_LOAD_MOD, 0, '1));
    add_row(row(CMD_LOAD_EXP, 0, 64'd2));
    add_row(row(CMD_START, 0, '0));
    add_row(row(CMD_LOAD_BASE, 15, '0));
    add_row(row(CMD_LOAD_BASE, 0, '0));
    add_row(row(CMD_START, 0, '0));
    add_row(row(CMD_LOAD_EXP, 0, '0));
    add_row(row(CMD_START, 0, '0, 1, 64'd1, 0));
    add_row(row(CMD_LOAD_EXP, 0, 64'd5));
    add_row(row(CMD_LOAD_BASE, 0, 64'd7));
    add_row(row(CMD_START, 0, '0));
    foreach (rows[i]) send_request(rows[i].req, rows[i].known, rows[i].known_w0,
                                   rows[i].known_err);

    // Random rounds of loads closed by a start. The exponent is kept short
    // before each start, as each exponent bit costs a bit-serial squaring.
    sent = 3 * NWORDS + rows.size();
    rounds = 0;
    while (sent < 260) begin
      if (sent > 200) idling = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        for (int k = 0; k < NWORDS; k++) begin
          send_request(make_req(CMD_LOAD_MOD, k, (k == 0 && rounds % 2 == 1) ?
                                random_word() : '0));
          sent++;
        end
      end
      repeat ($urandom_range(4, 16)) begin
        send_request(make_req(cmd_t'($urandom_range(0, 2)), $urandom_range(0, 15),
                              random_word()));
        sent++;
      end
      for (int k = 1; k < NWORDS; k++)
        if (exp_w[k] != 0) begin
          send_request(make_req(CMD_LOAD_EXP, k, '0));
          sent++;
        end
      e0 = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(0, 4095))
                                         : 64'($urandom_range(0, 63));
      if (exp_w[0] != e0) begin
        send_request(make_req(CMD_LOAD_EXP, 0, e0));
        sent++;
      end
      send_request(make_req(CMD_START, $urandom_range(0, 15), random_word()));
      sent++;
      rounds++;
    end
    in_valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/modexp_pkg.sv
hw/rtl/modexp_dp.sv
hw/rtl/modexp_ctrl.sv
hw/rtl/modular_exponentiation.sv
tb/sv/modular_exponentiation_test.sv
